// ===== hdl/ffea_pkg.sv =====
// Shared types and constants for the first-fit extent allocator.
package ffea_pkg;

    localparam int FIELD_W    = 48;
    localparam int VAL_W      = 49;
    localparam int COUNT_W    = 7;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    localparam logic [APB_ADDR_W-1:0] REG_POOL_BASE = 4'h0;
    localparam logic [APB_ADDR_W-1:0] REG_POOL_SIZE = 4'h8;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_REINIT = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_OVERLAP = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    rd_cur;
        logic    rd_nxt;
        logic    inc_idx;
        logic    wr_trim;
        logic    wr_low;
        logic    wr_high_end;
        logic    wr_join;
        logic    wr_new;
        logic    reinit;
        logic    mv_down;
        logic    mv_down_nxt;
        logic    mv_up;
        logic    mv_rd;
        logic    mv_wr;
        logic    grant;
        logic    pend_add;
        logic    pend_sub;
        logic    pend_inc;
        logic    pend_dec;
        logic    finish;
        status_t code;
    } ffea_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t act;
        logic    zero_size;
        logic    wrap;
        logic    empty;
        logic    last;
        logic    full;
        logic    fit;
        logic    exact;
        logic    past;
        logic    below;
        logic    touch_low;
        logic    touch_high;
        logic    over;
        logic    mv_more;
        logic    mv_up;
        logic    out_free;
    } ffea_stat_t;

endpackage

// ===== hdl/ffea_if.sv =====
// Valid/ready channel interfaces for request and result words.
interface ffea_item_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [ffea_pkg::FIELD_W-1:0] item_address;
    logic [ffea_pkg::FIELD_W-1:0] item_size;

    modport source (output valid, action, item_address, item_size, input ready);
    modport sink (input valid, action, item_address, item_size, output ready);
endinterface

interface ffea_result_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [ffea_pkg::FIELD_W-1:0] granted_address;
    logic [ffea_pkg::FIELD_W-1:0] free_total;
    logic [ffea_pkg::COUNT_W-1:0] extent_count;

    modport source (output valid, status, granted_address, free_total, extent_count,
                    input ready);
    modport sink (input valid, status, granted_address, free_total, extent_count,
                  output ready);
endinterface

// ===== hdl/ffea_ctrl.sv =====
// Controller state machine that sequences scans, shifts and updates.
module ffea_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  ffea_pkg::ffea_stat_t stat,
    output ffea_pkg::ffea_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_SCAN     = 8'b0000_0100,
        S_NEXT     = 8'b0000_1000,
        S_INSERT   = 8'b0001_0000,
        S_MOVE_CHK = 8'b0010_0000,
        S_MOVE_WR  = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    ffea_pkg::status_t   code_reg, code_next;

    assign item_ready = (state_reg == S_IDLE);

    // State and result code registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ffea_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    code_next  = ffea_pkg::ST_OK;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.act)
                    ffea_pkg::ACT_ALLOC:
                    begin
                        if (stat.empty)
                        begin
                            code_next  = ffea_pkg::ST_NO_FIT;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.rd_cur = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    ffea_pkg::ACT_FREE:
                    begin
                        if (stat.zero_size)
                        begin
                            state_next = S_FIN;
                        end
                        else if (stat.wrap)
                        begin
                            code_next  = ffea_pkg::ST_OVERLAP;
                            state_next = S_FIN;
                        end
                        else if (stat.empty)
                        begin
                            state_next = S_INSERT;
                        end
                        else
                        begin
                            cmd.rd_cur = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    ffea_pkg::ACT_REINIT:
                    begin
                        cmd.reinit = 1'b1;
                        state_next = S_FIN;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.act == ffea_pkg::ACT_ALLOC)
                begin
                    if (stat.fit)
                    begin
                        cmd.grant    = 1'b1;
                        cmd.pend_sub = 1'b1;
                        if (stat.exact)
                        begin
                            cmd.mv_down  = 1'b1;
                            cmd.pend_dec = 1'b1;
                            state_next   = S_MOVE_CHK;
                        end
                        else
                        begin
                            cmd.wr_trim = 1'b1;
                            state_next  = S_FIN;
                        end
                    end
                    else if (stat.last)
                    begin
                        code_next  = ffea_pkg::ST_NO_FIT;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.rd_nxt  = 1'b1;
                        cmd.inc_idx = 1'b1;
                    end
                end
                else
                begin
                    if (stat.past)
                    begin
                        cmd.inc_idx = 1'b1;
                        if (stat.last)
                        begin
                            state_next = S_INSERT;
                        end
                        else
                        begin
                            cmd.rd_nxt = 1'b1;
                        end
                    end
                    else if (stat.below)
                    begin
                        state_next = S_INSERT;
                    end
                    else if (stat.touch_low)
                    begin
                        cmd.wr_low   = 1'b1;
                        cmd.pend_add = 1'b1;
                        state_next   = S_FIN;
                    end
                    else if (stat.touch_high)
                    begin
                        if (stat.last)
                        begin
                            cmd.wr_high_end = 1'b1;
                            cmd.pend_add    = 1'b1;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            cmd.rd_nxt = 1'b1;
                            state_next = S_NEXT;
                        end
                    end
                    else
                    begin
                        code_next  = ffea_pkg::ST_OVERLAP;
                        state_next = S_FIN;
                    end
                end
            end
            S_NEXT:
            begin
                // Read data holds the following extent.
                if (stat.over)
                begin
                    code_next  = ffea_pkg::ST_OVERLAP;
                    state_next = S_FIN;
                end
                else if (stat.touch_low)
                begin
                    cmd.wr_join     = 1'b1;
                    cmd.mv_down_nxt = 1'b1;
                    cmd.pend_dec    = 1'b1;
                    cmd.pend_add    = 1'b1;
                    state_next      = S_MOVE_CHK;
                end
                else
                begin
                    cmd.wr_high_end = 1'b1;
                    cmd.pend_add    = 1'b1;
                    state_next      = S_FIN;
                end
            end
            S_INSERT:
            begin
                if (stat.full)
                begin
                    code_next  = ffea_pkg::ST_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.mv_up    = 1'b1;
                    cmd.pend_inc = 1'b1;
                    cmd.pend_add = 1'b1;
                    state_next   = S_MOVE_CHK;
                end
            end
            S_MOVE_CHK:
            begin
                if (stat.mv_more)
                begin
                    cmd.mv_rd  = 1'b1;
                    state_next = S_MOVE_WR;
                end
                else
                begin
                    cmd.wr_new = stat.mv_up;
                    state_next = S_FIN;
                end
            end
            S_MOVE_WR:
            begin
                cmd.mv_wr  = 1'b1;
                state_next = S_MOVE_CHK;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ffea_datapath.sv =====
// Extent table memory, item registers, counters and result register.
module ffea_datapath
#(
    parameter int MAX_EXTENTS  = 64,
    parameter int ADDRESS_BITS = 48
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffea_pkg::ffea_cmd_t           cmd,
    output ffea_pkg::ffea_stat_t          stat,
    input  logic [1:0]                    action,
    input  logic [ffea_pkg::FIELD_W-1:0]  item_address,
    input  logic [ffea_pkg::FIELD_W-1:0]  item_size,
    input  logic [ffea_pkg::FIELD_W-1:0]  pool_base,
    input  logic [ffea_pkg::FIELD_W-1:0]  pool_size,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [1:0]                    res_status,
    output logic [ffea_pkg::FIELD_W-1:0]  res_granted,
    output logic [ffea_pkg::FIELD_W-1:0]  res_free,
    output logic [ffea_pkg::COUNT_W-1:0]  res_count
);

    localparam int FW = ffea_pkg::FIELD_W;
    localparam int VW = ffea_pkg::VAL_W;
    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [VW-1:0] AMASK = (ADDRESS_BITS >= VW) ? {VW{1'b1}}
                                      : ((VW'(1) << ADDRESS_BITS) - VW'(1));
    localparam logic [FW-1:0] FMASK = AMASK[FW-1:0];
    localparam logic [CW-1:0] MAX_N = CW'(MAX_EXTENTS);

    // Extent table.
    logic [VW-1:0] low_mem  [MAX_EXTENTS];
    logic [VW-1:0] high_mem [MAX_EXTENTS];

    ffea_pkg::action_t act_reg;
    logic [FW-1:0]     addr_reg, size_reg;
    logic [CW-1:0]     idx_reg, p_reg, n_reg;
    logic              dir_up_reg;
    logic [FW-1:0]     free_reg, grant_reg;
    logic              p_add_reg, p_sub_reg, p_inc_reg, p_dec_reg;
    logic [VW-1:0]     rd_low_reg, rd_high_reg;
    logic              res_valid_reg;
    logic [1:0]        res_status_reg;
    logic [FW-1:0]     res_granted_reg, res_free_reg;
    logic [ffea_pkg::COUNT_W-1:0] res_count_reg;

    logic [VW-1:0] end_val, rd_size;
    logic [CW-1:0] rd_addr, idx_inc, n_next;
    logic          rd_en, low_we, high_we;
    logic [CW-1:0] wr_addr;
    logic [VW-1:0] low_wd, high_wd;
    logic [FW-1:0] rb, rs, free_next;
    logic [VW-1:0] r_lim, r_size;
    logic          ok;

    assign end_val = {1'b0, addr_reg} + {1'b0, size_reg};
    assign rd_size = rd_high_reg - rd_low_reg;
    assign idx_inc = idx_reg + CW'(1);

    // Pool bounds for reinitialize, clipped at the top of the address space.
    assign rb     = pool_base & FMASK;
    assign rs     = pool_size & FMASK;
    assign r_lim  = AMASK - {1'b0, rb};
    assign r_size = ({1'b0, rs} > r_lim) ? r_lim : {1'b0, rs};

    // Status toward the controller.
    always_comb
    begin
        stat            = '0;
        stat.act        = act_reg;
        stat.zero_size  = (size_reg == '0);
        stat.wrap       = (end_val > AMASK);
        stat.empty      = (n_reg == '0);
        stat.last       = (idx_inc == n_reg);
        stat.full       = (n_reg >= MAX_N);
        stat.fit        = (rd_size >= {1'b0, size_reg});
        stat.exact      = (rd_size == {1'b0, size_reg});
        stat.past       = ({1'b0, addr_reg} > rd_high_reg);
        stat.below      = (end_val < rd_low_reg);
        stat.touch_low  = (end_val == rd_low_reg);
        stat.touch_high = ({1'b0, addr_reg} == rd_high_reg);
        stat.over       = (end_val > rd_low_reg);
        stat.mv_more    = dir_up_reg ? (p_reg > idx_reg) : ((p_reg + CW'(1)) < n_reg);
        stat.mv_up      = dir_up_reg;
        stat.out_free   = !res_valid_reg || res_ready;
    end

    // Read address selection.
    always_comb
    begin
        rd_en = cmd.rd_cur | cmd.rd_nxt | cmd.mv_rd;
        if (cmd.mv_rd)
        begin
            rd_addr = dir_up_reg ? (p_reg - CW'(1)) : (p_reg + CW'(1));
        end
        else if (cmd.rd_nxt)
        begin
            rd_addr = idx_inc;
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    // Write port selection.
    always_comb
    begin
        low_we  = 1'b0;
        high_we = 1'b0;
        wr_addr = idx_reg;
        low_wd  = {1'b0, addr_reg};
        high_wd = end_val;
        if (cmd.wr_trim)
        begin
            low_we = 1'b1;
            low_wd = rd_low_reg + {1'b0, size_reg};
        end
        if (cmd.wr_low)
        begin
            low_we = 1'b1;
        end
        if (cmd.wr_high_end)
        begin
            high_we = 1'b1;
        end
        if (cmd.wr_join)
        begin
            high_we = 1'b1;
            high_wd = rd_high_reg;
        end
        if (cmd.wr_new)
        begin
            low_we  = 1'b1;
            high_we = 1'b1;
        end
        if (cmd.reinit)
        begin
            low_we  = (r_size != '0);
            high_we = (r_size != '0);
            wr_addr = '0;
            low_wd  = {1'b0, rb};
            high_wd = {1'b0, rb} + r_size;
        end
        if (cmd.mv_wr)
        begin
            low_we  = 1'b1;
            high_we = 1'b1;
            wr_addr = p_reg;
            low_wd  = rd_low_reg;
            high_wd = rd_high_reg;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (low_we)
        begin
            low_mem[wr_addr[AW-1:0]] <= low_wd;
        end
        if (high_we)
        begin
            high_mem[wr_addr[AW-1:0]] <= high_wd;
        end
        if (rd_en)
        begin
            rd_low_reg  <= low_mem[rd_addr[AW-1:0]];
            rd_high_reg <= high_mem[rd_addr[AW-1:0]];
        end
    end

    // Totals after the operation.
    assign ok = (cmd.code == ffea_pkg::ST_OK);
    always_comb
    begin
        n_next    = n_reg;
        free_next = free_reg;
        if (ok)
        begin
            if (p_inc_reg)
            begin
                n_next = n_reg + CW'(1);
            end
            else if (p_dec_reg)
            begin
                n_next = n_reg - CW'(1);
            end
            if (p_add_reg)
            begin
                free_next = (free_reg + size_reg) & FMASK;
            end
            else if (p_sub_reg)
            begin
                free_next = (free_reg - size_reg) & FMASK;
            end
        end
    end

    // Item registers and scan pointers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= ffea_pkg::action_t'(action);
            addr_reg  <= item_address & FMASK;
            size_reg  <= item_size & FMASK;
            idx_reg   <= '0;
            grant_reg <= '0;
        end
        else if (cmd.inc_idx)
        begin
            idx_reg <= idx_inc;
        end
        if (cmd.grant)
        begin
            grant_reg <= rd_low_reg[FW-1:0];
        end
        if (cmd.mv_down)
        begin
            p_reg      <= idx_reg;
            dir_up_reg <= 1'b0;
        end
        else if (cmd.mv_down_nxt)
        begin
            p_reg      <= idx_inc;
            dir_up_reg <= 1'b0;
        end
        else if (cmd.mv_up)
        begin
            p_reg      <= n_reg;
            dir_up_reg <= 1'b1;
        end
        else if (cmd.mv_wr)
        begin
            p_reg <= dir_up_reg ? (p_reg - CW'(1)) : (p_reg + CW'(1));
        end
        else if (cmd.load)
        begin
            dir_up_reg <= 1'b0;
        end
        if (cmd.finish)
        begin
            res_status_reg  <= cmd.code;
            res_granted_reg <= ok ? grant_reg : '0;
            res_free_reg    <= free_next;
            res_count_reg   <= ffea_pkg::COUNT_W'(n_next);
        end
    end

    // Control state: counts, pending updates and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            free_reg      <= '0;
            p_add_reg     <= 1'b0;
            p_sub_reg     <= 1'b0;
            p_inc_reg     <= 1'b0;
            p_dec_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                p_add_reg <= 1'b0;
                p_sub_reg <= 1'b0;
                p_inc_reg <= 1'b0;
                p_dec_reg <= 1'b0;
            end
            else
            begin
                p_add_reg <= p_add_reg | cmd.pend_add;
                p_sub_reg <= p_sub_reg | cmd.pend_sub;
                p_inc_reg <= p_inc_reg | cmd.pend_inc;
                p_dec_reg <= p_dec_reg | cmd.pend_dec;
            end
            if (cmd.reinit)
            begin
                n_reg    <= (r_size != '0) ? CW'(1) : '0;
                free_reg <= r_size[FW-1:0];
            end
            else if (cmd.finish)
            begin
                n_reg    <= n_next;
                free_reg <= free_next;
            end
            if (cmd.finish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_status  = res_status_reg;
    assign res_granted = res_granted_reg;
    assign res_free    = res_free_reg;
    assign res_count   = res_count_reg;

endmodule

// ===== hdl/first_fit_extent_allocator_unit.sv =====
// Top level of the first-fit extent allocator with coalescing free.
//
// Usage: request words arrive on the item channel (action, item_address,
// item_size) and every request yields exactly one word on the result channel
// (status, granted_address, free_total, extent_count). pool_base and
// pool_size are written over the APB port at byte addresses 0 and 8 while
// the block is idle.
// A result is registered once its word has been accepted and dispatched, after
// a scan step for every table entry scanned, a read and a write for every entry
// shifted, and setup steps for a shift, an insert or a join. The extent table
// does one read and one write per shift step; one item is worked on at a time,
// and the next word is accepted once its result is registered.
// The result sits in an output register, so the next word is accepted as
// soon as the previous one has finished, even while its result waits.
// Reset empties the table and clears the totals and the pool registers; no
// clearing pass is needed. When the receiver stalls, the finished result
// holds and the block waits with the next result until the register frees.
module first_fit_extent_allocator_unit
#(
    parameter int MAX_EXTENTS  = 64,
    parameter int ADDRESS_BITS = 48
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    ffea_item_if.sink                         item,
    ffea_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ffea_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ffea_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ffea_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int FW = ffea_pkg::FIELD_W;

    logic [FW-1:0]        pool_base_reg, pool_size_reg;
    ffea_pkg::ffea_cmd_t  cmd;
    ffea_pkg::ffea_stat_t stat;
    logic                 wr_en;

    // Configuration registers.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            pool_size_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                ffea_pkg::REG_POOL_BASE: pool_base_reg <= pwdata[FW-1:0];
                ffea_pkg::REG_POOL_SIZE: pool_size_reg <= pwdata[FW-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr)
            ffea_pkg::REG_POOL_BASE: prdata = ffea_pkg::APB_DATA_W'(pool_base_reg);
            ffea_pkg::REG_POOL_SIZE: prdata = ffea_pkg::APB_DATA_W'(pool_size_reg);
            default:                 prdata = '0;
        endcase
    end

    ffea_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    ffea_datapath
    #(
        .MAX_EXTENTS  (MAX_EXTENTS),
        .ADDRESS_BITS (ADDRESS_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (item.action),
        .item_address (item.item_address),
        .item_size    (item.item_size),
        .pool_base    (pool_base_reg),
        .pool_size    (pool_size_reg),
        .res_valid    (result.valid),
        .res_ready    (result.ready),
        .res_status   (result.status),
        .res_granted  (result.granted_address),
        .res_free     (result.free_total),
        .res_count    (result.extent_count)
    );

endmodule

// ===== hdl/ffea_checker.sv =====
// Port-level checker for the extent allocator and its bind.
module ffea_checker
#(
    parameter int MAX_EXTENTS = 64
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [1:0]                   res_status,
    input logic [ffea_pkg::FIELD_W-1:0] res_granted,
    input logic [ffea_pkg::FIELD_W-1:0] res_free,
    input logic [ffea_pkg::COUNT_W-1:0] res_count,
    input logic                         pready
);

    localparam bit SMALL = (MAX_EXTENTS < 128);

    // A stalled result word stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    // A failed operation never reports a granted address.
    a_grant: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status != ffea_pkg::ST_OK) |-> res_granted == '0)
        else $error("granted address on failed operation");

    // The table never holds more extents than it has room for.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && SMALL |-> res_count <= ffea_pkg::COUNT_W'(MAX_EXTENTS))
        else $error("extent count beyond table size");

    // An empty table has no free bytes.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && SMALL && (res_count == '0) |-> res_free == '0)
        else $error("free bytes reported with empty table");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind first_fit_extent_allocator_unit ffea_checker
#(
    .MAX_EXTENTS (MAX_EXTENTS)
)
u_ffea_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_status  (result.status),
    .res_granted (result.granted_address),
    .res_free    (result.free_total),
    .res_count   (result.extent_count),
    .pready      (pready)
);

// ===== tb/sv/first_fit_extent_allocator_unit_test.sv =====
// Self-checking testbench for the first-fit extent allocator unit.
`timescale 1ns / 1ps

module first_fit_extent_allocator_unit_test;

    localparam int FW          = ffea_pkg::FIELD_W;
    localparam int CNTW        = ffea_pkg::COUNT_W;
    localparam int PAW         = ffea_pkg::APB_ADDR_W;
    localparam int PDW         = ffea_pkg::APB_DATA_W;
    localparam int SLOTS       = 64;
    localparam int SETTLE      = 4 * SLOTS + 16;
    localparam int STALL_LIMIT = 20000;
    localparam bit [FW-1:0] TOP_ADDRESS = '1;

    typedef struct {
        ffea_pkg::status_t status;
        bit [FW-1:0]       granted;
        bit [FW-1:0]       free_total;
        bit [CNTW-1:0]     count;
    } outcome_t;

    typedef struct {
        bit [FW-1:0] start;
        bit [FW-1:0] bytes;
    } span_t;

    // Mirror of the free-extent table together with the queue of pending outcomes.
    class extent_scoreboard;
        bit [FW-1:0] lo [SLOTS];
        bit [FW-1:0] hi [SLOTS];
        int          used;
        bit [FW-1:0] free_bytes;
        bit [FW-1:0] pool_base;
        bit [FW-1:0] pool_size;
        outcome_t    pending [$];
        span_t       held [$];
        int          errors;

        function new();
            used = 0;
            free_bytes = 0;
            pool_base = 0;
            pool_size = 0;
            errors = 0;
        endfunction

        function ffea_pkg::status_t carve(bit [FW-1:0] req, output bit [FW-1:0] granted);
            bit [FW-1:0] span_len;
            span_t       grant_span;
            granted = 0;
            for (int i = 0; i < used; i++)
            begin
                span_len = hi[i] - lo[i];
                if (span_len >= req)
                begin
                    granted = lo[i];
                    if (span_len == req)
                    begin
                        for (int j = i; j < used - 1; j++)
                        begin
                            lo[j] = lo[j+1];
                            hi[j] = hi[j+1];
                        end
                        used--;
                    end
                    else
                        lo[i] += req;
                    free_bytes -= req;
                    if (req != 0)
                    begin
                        grant_span.start = granted;
                        grant_span.bytes = req;
                        held.push_back(grant_span);
                    end
                    return ffea_pkg::ST_OK;
                end
            end
            return ffea_pkg::ST_NO_FIT;
        endfunction

        function ffea_pkg::status_t give_back(bit [FW-1:0] a, bit [FW-1:0] s);
            bit [FW:0]   wide_end;
            bit [FW-1:0] stop;
            int          i;
            if (s == 0)
                return ffea_pkg::ST_OK;
            wide_end = {1'b0, a} + {1'b0, s};
            if (wide_end > {1'b0, TOP_ADDRESS})
                return ffea_pkg::ST_OVERLAP;
            stop = wide_end[FW-1:0];
            i = 0;
            while (i < used && a > hi[i])
                i++;
            if (i == used || stop < lo[i])
            begin
                if (used >= SLOTS)
                    return ffea_pkg::ST_FULL;
                for (int j = used; j > i; j--)
                begin
                    lo[j] = lo[j-1];
                    hi[j] = hi[j-1];
                end
                lo[i] = a;
                hi[i] = stop;
                used++;
            end
            else if (stop == lo[i])
                lo[i] = a;
            else if (a == hi[i])
            begin
                if (i + 1 < used && stop > lo[i+1])
                    return ffea_pkg::ST_OVERLAP;
                hi[i] = stop;
                // Closing the gap to the next extent joins both neighbors.
                if (i + 1 < used && stop == lo[i+1])
                begin
                    hi[i] = hi[i+1];
                    for (int j = i + 1; j < used - 1; j++)
                    begin
                        lo[j] = lo[j+1];
                        hi[j] = hi[j+1];
                    end
                    used--;
                end
            end
            else
                return ffea_pkg::ST_OVERLAP;
            free_bytes += s;
            return ffea_pkg::ST_OK;
        endfunction

        function void restart_pool();
            bit [FW-1:0] span_len;
            span_len = pool_size;
            if (span_len > TOP_ADDRESS - pool_base)
                span_len = TOP_ADDRESS - pool_base;
            held.delete();
            if (span_len == 0)
            begin
                used = 0;
                free_bytes = 0;
            end
            else
            begin
                lo[0] = pool_base;
                hi[0] = pool_base + span_len;
                used = 1;
                free_bytes = span_len;
            end
        endfunction

        // Predicts the outcome of one accepted request word.
        function void note_request(ffea_pkg::action_t act, bit [FW-1:0] a, bit [FW-1:0] s);
            outcome_t o;
            o.status = ffea_pkg::ST_OK;
            o.granted = 0;
            case (act)
                ffea_pkg::ACT_ALLOC:  o.status = carve(s, o.granted);
                ffea_pkg::ACT_FREE:   o.status = give_back(a, s);
                ffea_pkg::ACT_REINIT: restart_pool();
                default:              ;
            endcase
            if (o.status != ffea_pkg::ST_OK)
                o.granted = 0;
            o.free_total = free_bytes;
            o.count = used[CNTW-1:0];
            pending.push_back(o);
        endfunction

        // Compares one accepted result word with the oldest prediction.
        function void check_result(outcome_t got);
            outcome_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word status=%0d", $time, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.granted != want.granted)
            begin
                $display("%0t: granted_address expected %h actual %h",
                         $time, want.granted, got.granted);
                errors++;
            end
            if (got.free_total != want.free_total)
            begin
                $display("%0t: free_total expected %h actual %h",
                         $time, want.free_total, got.free_total);
                errors++;
            end
            if (got.count != want.count)
            begin
                $display("%0t: extent_count expected %0d actual %0d",
                         $time, want.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [PAW-1:0] paddr;
    logic [PDW-1:0] pwdata;
    logic [PDW-1:0] prdata;
    logic           pready;

    ffea_item_if   item_ch ();
    ffea_result_if result_ch ();

    extent_scoreboard sb;
    int               send_idle;
    int               recv_idle;
    int               quiet_cycles;

    first_fit_extent_allocator_unit uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock generation.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver stalls at random according to the current idle rate.
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Result monitor.
    always @(posedge clk)
    begin
        outcome_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.status = ffea_pkg::status_t'(result_ch.status);
            got.granted = result_ch.granted_address;
            got.free_total = result_ch.free_total;
            got.count = result_ch.extent_count;
            sb.check_result(got);
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sends one request word, with random idle cycles ahead of it.
    task automatic send_request(ffea_pkg::action_t act, bit [FW-1:0] a, bit [FW-1:0] s);
        while ($urandom_range(99) < send_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.action <= act;
        item_ch.item_address <= a;
        item_ch.item_size <= s;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_request(act, a, s);
    endtask

    // Drops valid and waits until every predicted result has arrived and the block settles.
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(logic [PAW-1:0] where, bit [FW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= where;
        pwdata <= {{(PDW-FW){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (where == ffea_pkg::REG_POOL_BASE)
            sb.pool_base = value;
        else
            sb.pool_size = value;
    endtask

    // Sets a new pool while idle and starts it with a reinitialize.
    task automatic set_pool(bit [FW-1:0] base, bit [FW-1:0] bytes);
        drain();
        write_register(ffea_pkg::REG_POOL_BASE, base);
        write_register(ffea_pkg::REG_POOL_SIZE, bytes);
        send_request(ffea_pkg::ACT_REINIT, 0, 0);
    endtask

    function automatic bit [FW-1:0] wide_random();
        return FW'({$urandom(), $urandom()});
    endfunction

    // Mostly well-formed allocate and free traffic, with some noise.
    task automatic random_traffic(int count);
        int          pick;
        int          idx;
        span_t       sp;
        bit [FW-1:0] part;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45 || (pick < 85 && sb.held.size() == 0))
            begin
                if ($urandom_range(19) == 0)
                    send_request(ffea_pkg::ACT_ALLOC, wide_random(),
                                 wide_random() >> $urandom_range(47));
                else
                    send_request(ffea_pkg::ACT_ALLOC, wide_random(),
                                 FW'($urandom_range(48, 1)));
            end
            else if (pick < 85)
            begin
                idx = $urandom_range(sb.held.size() - 1);
                sp = sb.held[idx];
                sb.held.delete(idx);
                // Sometimes return only the front part of an allocation.
                if (sp.bytes > 1 && $urandom_range(3) == 0)
                begin
                    part = sp.bytes / 2;
                    sb.held.push_back('{sp.start + part, sp.bytes - part});
                    sp.bytes = part;
                end
                send_request(ffea_pkg::ACT_FREE, sp.start, sp.bytes);
            end
            else if (pick < 89)
                send_request(ffea_pkg::ACT_REINIT, wide_random(), wide_random());
            else if (pick < 97)
                send_request(ffea_pkg::ACT_FREE, wide_random() >> $urandom_range(47),
                             wide_random() >> $urandom_range(47));
            else
                send_request(ffea_pkg::ACT_NONE, wide_random(), wide_random());
        end
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.action = ffea_pkg::ACT_NONE;
        item_ch.item_address = '0;
        item_ch.item_size = '0;
        result_ch.ready = 1'b0;
        quiet_cycles = 0;
        send_idle = 13;
        recv_idle = 67;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: requests on the empty table, then the basic cases.
        send_request(ffea_pkg::ACT_ALLOC, 0, 0);
        send_request(ffea_pkg::ACT_FREE, 0, 0);
        set_pool(100, 1000);
        send_request(ffea_pkg::ACT_ALLOC, TOP_ADDRESS, 0);
        send_request(ffea_pkg::ACT_ALLOC, 0, 100);
        send_request(ffea_pkg::ACT_ALLOC, 0, 200);
        send_request(ffea_pkg::ACT_ALLOC, 0, TOP_ADDRESS);
        send_request(ffea_pkg::ACT_FREE, 500, 10);
        send_request(ffea_pkg::ACT_FREE, TOP_ADDRESS, 2);
        send_request(ffea_pkg::ACT_FREE, TOP_ADDRESS, 1);
        send_request(ffea_pkg::ACT_FREE, 100, 100);
        send_request(ffea_pkg::ACT_FREE, 200, 200);
        send_request(ffea_pkg::ACT_ALLOC, 0, 1000);
        send_request(ffea_pkg::ACT_FREE, 0, 50);
        send_request(ffea_pkg::ACT_FREE, 50, 50);
        send_request(ffea_pkg::ACT_NONE, TOP_ADDRESS, TOP_ADDRESS);
        send_request(ffea_pkg::ACT_REINIT, 0, 0);

        // Fragment the table until it fills up.
        for (int k = 0; k < 140; k++)
            send_request(ffea_pkg::ACT_ALLOC, 0, 1);
        for (int k = 0; k < 70; k++)
            send_request(ffea_pkg::ACT_FREE, FW'(100 + 2 * k), 1);
        send_request(ffea_pkg::ACT_REINIT, 0, 0);
        random_traffic(250);

        set_pool(0, TOP_ADDRESS);
        random_traffic(150);

        send_idle = 67;
        recv_idle = 13;
        set_pool(TOP_ADDRESS, TOP_ADDRESS);
        random_traffic(100);
        set_pool(TOP_ADDRESS - 200, 5000);
        random_traffic(200);

        send_idle = 0;
        recv_idle = 0;
        set_pool(0, 0);
        random_traffic(100);
        set_pool(48'h1234_5678_9abc, 65536);
        random_traffic(200);

        drain();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
